/* rtl/image_cubic_interpolator_macros.svh */
// Assertion macros for the interpolator.
`ifndef IMAGE_CUBIC_INTERPOLATOR_MACROS_SVH
`define IMAGE_CUBIC_INTERPOLATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define ICI_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ICI_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ICI_ASSERT(label, clk, rst, prop, msg)
`define ICI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/ici_pkg.sv */
`timescale 1ns / 1ps
package ici_pkg;
  localparam int MAX_ROWS_D = 256;
  localparam int MAX_COLS_D = 256;
  localparam int COORD_FRAC_BITS_D = 8;
  localparam int CHANNELS_D = 3;
  localparam int NLANES = 3;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;
  localparam logic [1:0] REG_HEIGHT = 2'd0;
  localparam logic [1:0] REG_WIDTH = 2'd1;
  localparam logic [1:0] REG_MODE = 2'd2;
  localparam logic MODE_CUBIC = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] pixel_row;
    logic [7:0] pixel_col;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    logic [15:0] sample_row;
    logic [15:0] sample_col;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [9:0] channel_sum;
  } out_req_t;

  // lane control from sequencer
  typedef struct packed {
    logic clr_col;  // start new column accumulation
    logic col_en;   // accumulate pixel*wx
    logic row_en;   // fold column result into row acc (weight wy)
    logic clr_row;
  } lane_ctl_t;

  typedef enum logic [2:0] {S_IDLE, S_WGT, S_READ, S_DRAIN, S_FIN, S_OUT} state_t;

  // Round-half-up divide by 6*2^32 of a signed value |n| < 2^53.
  // Done as multiply by reciprocal in ici_weight over cycles; the package
  // itself holds no helper for it.
endpackage

/* rtl/ici_weight.sv */
`timescale 1ns / 1ps
// Computes the four cubic weights for one Q16 fraction over several cycles.
module ici_weight import ici_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [16:0] t,
  output logic done,
  output logic signed [18:0] w0,
  output logic signed [18:0] w1,
  output logic signed [18:0] w2,
  output logic signed [18:0] w3
);
  // n = a*b*c with |factors| < 2^18; two multiplies per term, one per cycle.
  logic [3:0] step;
  logic signed [18:0] ta, tb, tc;   // T-U, T-2U, T+U
  logic signed [37:0] p;            // partial product
  logic signed [55:0] n;
  logic signed [55:0] x;
  logic signed [18:0] q;
  logic signed [18:0] r0, r2, r3;

  // floor(x / D), D = 6*2^32: floor(x>>32) then floor by 6 via small correction
  logic signed [23:0] hi;
  logic signed [23:0] qq;
  logic signed [23:0] rem;
  always_comb begin
    hi = x[55:32];
    qq = 24'(($signed({{19{hi[23]}}, hi}) * 43'sd43691) >>> 18);
    rem = hi - qq * 24'sd6;
    if (rem < 0) qq = qq - 24'sd1;
    else if (rem >= 24'sd6) qq = qq + 24'sd1;
    q = 19'(qq);
  end

  always_comb begin
    ta = $signed({2'b0, t}) - 19'sd65536;
    tb = $signed({2'b0, t}) - 19'sd131072;
    tc = $signed({2'b0, t}) + 19'sd65536;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) step <= 4'd1;
      else if (step != 0) begin
        step <= (step == 4'd9) ? 4'd0 : step + 4'd1;
        if (step == 4'd9) done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (step)
      4'd1: p <= 38'(ta * tb);
      4'd2: begin n <= -(56'(p) * $signed({2'b0, t})); p <= 38'(tc * tb); end
      4'd3: begin x <= n + (56'sd3 <<< 32); n <= -(56'(p) * $signed({2'b0, t})) * 56'sd3; end
      4'd4: begin r0 <= q; x <= n + (56'sd3 <<< 32); p <= 38'(tc * ta); end
      4'd5: begin r2 <= q; n <= 56'(p) * $signed({2'b0, t}); end
      4'd6: x <= n + (56'sd3 <<< 32);
      4'd7: r3 <= q;
      4'd8: begin
        w0 <= r0; w2 <= r2; w3 <= r3;
        w1 <= 19'sd65536 - r0 - r2 - r3;
      end
      default: ;
    endcase
  end
endmodule

/* rtl/ici_lane.sv */
`timescale 1ns / 1ps
// One color channel: column pass then row pass accumulation.
module ici_lane import ici_pkg::*; (
  input  logic clk,
  input  lane_ctl_t ctl,
  input  logic [7:0] pix,
  input  logic signed [18:0] wx,
  input  logic signed [18:0] wy,
  output logic [7:0] chan
);
  logic signed [28:0] colacc;
  logic signed [47:0] rowacc;
  logic signed [47:0] prod;
  logic signed [48:0] v;

  always_ff @(posedge clk) begin
    if (ctl.clr_col) colacc <= 29'(wx * $signed({1'b0, pix}));
    else if (ctl.col_en) colacc <= colacc + 29'(wx * $signed({1'b0, pix}));
    if (ctl.clr_row) rowacc <= '0;
    else if (ctl.row_en) rowacc <= rowacc + prod;
  end
  assign prod = 48'(colacc * wy);

  always_comb begin
    v = 49'(rowacc) + (49'sd1 <<< 31);
    if (v < 0) chan = 8'd0;
    else if (v[48:32] > 17'd255) chan = 8'd255;
    else chan = v[39:32];
  end
endmodule

/* rtl/image_cubic_interpolator.sv */
`timescale 1ns / 1ps
// Bicubic/bilinear RGB image interpolator over a pixel memory with one write and one read port.
// Write request: no result; accepted back to back while idle.
// Sample request: weights first, then one memory read per cycle (16 bicubic,
// 4 bilinear), a drain and a merge; the result is held in S_OUT until taken,
// and the next request is accepted only back in idle, so out stalls delay it.
// Reset (rst, synchronous) clears control, height/width 256, bicubic; memory kept.
`include "image_cubic_interpolator_macros.svh"
module image_cubic_interpolator import ici_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_D,
  parameter int MAX_COLS = MAX_COLS_D,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_D,
  parameter int CHANNELS = CHANNELS_D
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_req_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata
);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);

  logic [8:0] height, width;
  logic mode;
  state_t state, state_next;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      height <= 9'd256; width <= 9'd256; mode <= MODE_CUBIC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT: height <= cfg_wdata;
        REG_WIDTH: width <= cfg_wdata;
        REG_MODE: mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, clamp to store size.
  logic [12:0] h_eff, w_eff;
  always_comb begin
    h_eff = (height == 0) ? 13'd1 : (13'(height) > 13'(MAX_ROWS) ? 13'(MAX_ROWS) : 13'(height));
    w_eff = (width == 0) ? 13'd1 : (13'(width) > 13'(MAX_COLS) ? 13'(MAX_COLS) : 13'(width));
  end

  // Coordinate split with saturation
  logic [28:0] lim_r, lim_c, cr, cc;
  always_comb begin
    lim_r = 29'(h_eff) << COORD_FRAC_BITS;
    lim_c = 29'(w_eff) << COORD_FRAC_BITS;
    cr = (29'(in_data.sample_row) >= lim_r) ? lim_r - 29'd1 : 29'(in_data.sample_row);
    cc = (29'(in_data.sample_col) >= lim_c) ? lim_c - 29'd1 : 29'(in_data.sample_col);
  end

  logic [12:0] yi, xi, hm1, wm1;
  logic [16:0] ty, tx;
  logic lin;

  logic accept;
  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;

  // Pixel memory
  localparam int PW = 8 * CHANNELS;
  logic [PW-1:0] mem [MAX_ROWS*MAX_COLS];
  logic [PW-1:0] rdata;
  logic [RB+CB-1:0] raddr;
  always_ff @(posedge clk) begin
    if (accept && in_data.operation == OP_WRITE &&
        32'(in_data.pixel_row) < 32'(MAX_ROWS) && 32'(in_data.pixel_col) < 32'(MAX_COLS))
      mem[(RB+CB)'(32'(in_data.pixel_row) * 32'(MAX_COLS) + 32'(in_data.pixel_col))] <=
        PW'({in_data.in_blue, in_data.in_green, in_data.in_red});
    rdata <= mem[raddr];
  end

  // Weight units
  logic wstart, wdone_x, wdone_y;
  logic signed [18:0] cx0, cx1, cx2, cx3, cy0, cy1, cy2, cy3;
  ici_weight u_wx (.clk, .rst, .start(wstart), .t(tx), .done(wdone_x),
                   .w0(cx0), .w1(cx1), .w2(cx2), .w3(cx3));
  ici_weight u_wy (.clk, .rst, .start(wstart), .t(ty), .done(wdone_y),
                   .w0(cy0), .w1(cy1), .w2(cy2), .w3(cy3));

  // Read sequencer: k = column tap, i = row tap
  logic [1:0] ki, ii;
  logic [1:0] kd, id;       // taps of the word now on rdata
  logic rd_v, col_last_d;
  logic [1:0] drain;

  function automatic logic [12:0] clampi(input logic [12:0] base, input logic [1:0] off,
                                         input logic [12:0] hi, input logic l);
    logic signed [14:0] v;
    v = l ? $signed({2'b0, base}) + $signed({13'b0, off}) :
            $signed({2'b0, base}) + $signed({13'b0, off}) - 15'sd1;
    if (v < 0) return 13'd0;
    if (v > $signed({2'b0, hi})) return hi;
    return v[12:0];
  endfunction

  logic [12:0] rr, rc;
  always_comb begin
    rr = clampi(yi, ii, hm1, lin);
    rc = clampi(xi, ki, wm1, lin);
    raddr = (RB+CB)'(32'(rr) * 32'(MAX_COLS) + 32'(rc));
  end

  logic [1:0] tmax;
  assign tmax = lin ? 2'd1 : 2'd3;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && in_data.operation == OP_SAMPLE) state_next = S_WGT;
      S_WGT: if (wdone_x && wdone_y) state_next = S_READ;
      S_READ: if (ki == tmax && ii == tmax) state_next = S_DRAIN;
      S_DRAIN: if (drain == 2'd3) state_next = S_FIN;
      S_FIN: state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign wstart = (state == S_IDLE) && accept && in_data.operation == OP_SAMPLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; rd_v <= 1'b0; drain <= '0;
    end else begin
      state <= state_next;
      rd_v <= (state == S_READ);
      drain <= (state == S_DRAIN) ? drain + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (wstart) begin
      yi <= 13'(cr >> COORD_FRAC_BITS);
      xi <= 13'(cc >> COORD_FRAC_BITS);
      ty <= 17'(16'(cr[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS));
      tx <= 17'(16'(cc[COORD_FRAC_BITS-1:0]) << (16 - COORD_FRAC_BITS));
      hm1 <= h_eff - 13'd1; wm1 <= w_eff - 13'd1;
      lin <= mode; ki <= '0; ii <= '0;
    end else if (state == S_READ) begin
      if (ki == tmax) begin ki <= '0; ii <= ii + 2'd1; end
      else ki <= ki + 2'd1;
    end
    kd <= ki; id <= ii;
    col_last_d <= (ki == tmax);
  end

  // Weight select for the word on rdata (row weight applies in the cycle after the column's last word)
  logic signed [18:0] wxs, wys;
  logic [1:0] id2;
  logic rowen;
  always_comb begin
    if (lin) begin
      wxs = kd[0] ? $signed({2'b0, tx}) : 19'sd65536 - $signed({2'b0, tx});
      wys = id2[0] ? $signed({2'b0, ty}) : 19'sd65536 - $signed({2'b0, ty});
    end else begin
      case (kd)
        2'd0: wxs = cx0; 2'd1: wxs = cx1; 2'd2: wxs = cx2; default: wxs = cx3;
      endcase
      case (id2)
        2'd0: wys = cy0; 2'd1: wys = cy1; 2'd2: wys = cy2; default: wys = cy3;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (rst) rowen <= 1'b0;
    else rowen <= rd_v && col_last_d;
    id2 <= id;
  end

  lane_ctl_t ctl;
  always_comb begin
    ctl.clr_col = rd_v && kd == 2'd0;
    ctl.col_en = rd_v;
    ctl.row_en = rowen;
    ctl.clr_row = wstart;
  end

  logic [7:0] ch [NLANES];
  for (genvar g = 0; g < NLANES; g++) begin : g_lane
    logic [7:0] p;
    assign p = (g < CHANNELS) ? rdata[(g < CHANNELS ? g : 0)*8 +: 8] : 8'd0;
    ici_lane u_lane (.clk, .ctl, .pix(p), .wx(wxs), .wy(wys), .chan(ch[g]));
  end

  // Merge lanes into the result register
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      out_data.out_red <= ch[0];
      out_data.out_green <= ch[1];
      out_data.out_blue <= ch[2];
      out_data.channel_sum <= 10'(ch[0]) + 10'(ch[1]) + 10'(ch[2]);
    end
  end
  assign out_valid = (state == S_OUT);

  `ICI_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !accept, "accept while busy")
  `ICI_ASSERT(a_out_from_fin, clk, rst, $rose(out_valid) |-> $past(state) == S_FIN, "bad out")
  `ICI_ASSERT(a_sum, clk, rst, out_valid |-> out_data.channel_sum ==
    10'(out_data.out_red) + 10'(out_data.out_green) + 10'(out_data.out_blue), "sum")
endmodule

/* sim/interp_checker.sv */
`timescale 1ns / 1ps
module interp_checker import ici_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_stall,
  input  in_req_t in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_req_t out_data,
  input  logic cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  output int fail_count,
  output int pending
);
  logic [23:0] pixels [0:65535];
  logic [8:0] height_q, width_q;
  logic mode_q;
  out_req_t expected_pixels [$];

  function automatic longint round_w(longint n);
    longint d, x;
    d = 64'sd6 <<< 32;
    x = n + d / 2;
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic void cubic_w(longint t, output longint w [4]);
    longint u;
    u = 65536;
    w[0] = round_w(-t * (t - u) * (t - 2 * u));
    w[2] = round_w(-3 * (t + u) * t * (t - 2 * u));
    w[3] = round_w((t + u) * t * (t - u));
    w[1] = u - w[0] - w[2] - w[3];
  endfunction

  function automatic int clip(int v, int hi);
    return v < 0 ? 0 : (v > hi ? hi : v);
  endfunction

  function automatic longint px(int r, int c, int d);
    return longint'(pixels[r * 256 + c][8 * (2 - d) +: 8]);
  endfunction

  function automatic out_req_t interpolate(in_req_t q);
    out_req_t res;
    int h, w, yi, xi, lim, cy, cx, r, c, r1, c1;
    longint ty, tx, acc, colsum, v;
    longint wx [4];
    longint wy [4];
    int ch [3];
    h = height_q == 0 ? 1 : (height_q > 256 ? 256 : height_q);
    w = width_q == 0 ? 1 : (width_q > 256 ? 256 : width_q);
    lim = h << 8; cy = q.sample_row; if (cy >= lim) cy = lim - 1;
    lim = w << 8; cx = q.sample_col; if (cx >= lim) cx = lim - 1;
    yi = cy >> 8; ty = (cy & 255) << 8;
    xi = cx >> 8; tx = (cx & 255) << 8;
    cubic_w(tx, wx);
    cubic_w(ty, wy);
    for (int d = 0; d < 3; d++) begin
      acc = 0;
      if (mode_q == MODE_CUBIC) begin
        for (int i = 0; i < 4; i++) begin
          r = clip(yi - 1 + i, h - 1);
          colsum = 0;
          for (int k = 0; k < 4; k++) begin
            c = clip(xi - 1 + k, w - 1);
            colsum += px(r, c, d) * wx[k];
          end
          acc += colsum * wy[i];
        end
      end else begin
        r1 = clip(yi + 1, h - 1);
        c1 = clip(xi + 1, w - 1);
        acc = (65536 - ty) * ((65536 - tx) * px(yi, xi, d) + tx * px(yi, c1, d))
            + ty * ((65536 - tx) * px(r1, xi, d) + tx * px(r1, c1, d));
      end
      v = acc + (64'sd1 <<< 31);
      ch[d] = v < 0 ? 0 : ((v >>> 32) > 255 ? 255 : int'(v >>> 32));
    end
    res.out_red = 8'(ch[0]);
    res.out_green = 8'(ch[1]);
    res.out_blue = 8'(ch[2]);
    res.channel_sum = 10'(ch[0] + ch[1] + ch[2]);
    return res;
  endfunction

  assign pending = expected_pixels.size();

  always @(posedge clk) begin
    out_req_t e;
    if (rst) begin
      height_q <= 9'd256;
      width_q <= 9'd256;
      mode_q <= MODE_CUBIC;
      fail_count <= 0;
      expected_pixels.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HEIGHT: height_q <= cfg_wdata;
          REG_WIDTH: width_q <= cfg_wdata;
          REG_MODE: mode_q <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (in_data.operation == OP_WRITE)
          pixels[{in_data.pixel_row, in_data.pixel_col}] =
            {in_data.in_red, in_data.in_green, in_data.in_blue};
        else
          expected_pixels.push_back(interpolate(in_data));
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_pixels.pop_front();
          if (out_data !== e) begin
            if (out_data.out_red !== e.out_red)
              $error("out_red expected %0d got %0d", e.out_red, out_data.out_red);
            if (out_data.out_green !== e.out_green)
              $error("out_green expected %0d got %0d", e.out_green, out_data.out_green);
            if (out_data.out_blue !== e.out_blue)
              $error("out_blue expected %0d got %0d", e.out_blue, out_data.out_blue);
            if (out_data.channel_sum !== e.channel_sum)
              $error("channel_sum expected %0d got %0d", e.channel_sum,
                     out_data.channel_sum);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench import ici_pkg::*;;
  logic clk = 1'b0, rst = 1'b1;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  in_req_t in_data = '0;
  out_req_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = REG_HEIGHT;
  logic [8:0] cfg_wdata = '0;
  int fail_count, pending;
  // gate for random idling; cleared for a quiet stretch
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;
  // current image size, so sample-time reads only hit written pixels
  int img_h = 256, img_w = 256;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  image_cubic_interpolator dut (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata
  );

  interp_checker chk (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall,
    .out_data, .cfg_we, .cfg_index, .cfg_wdata, .fail_count, .pending
  );

  // Receiver: random stalls, plus one long hold-off while hold_off is set.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= idle_on && ($urandom_range(99) < 9);
  end

  // Send one request; random gaps before it, then wait for acceptance.
  // Valid stays up on return; the caller drops it when no request follows.
  task automatic push(in_req_t q);
    while (idle_on && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_data <= q;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic put_pixel(int r, int c, logic [23:0] rgb);
    in_req_t q;
    q = '0;
    q.operation = OP_WRITE;
    q.pixel_row = 8'(r);
    q.pixel_col = 8'(c);
    {q.in_red, q.in_green, q.in_blue} = rgb;
    q.sample_row = 16'($urandom);
    q.sample_col = 16'($urandom);
    push(q);
  endtask

  task automatic take_sample(logic [15:0] sr, logic [15:0] sc);
    in_req_t q;
    q = '0;
    {q.pixel_row, q.pixel_col, q.in_red, q.in_green} = $urandom;
    q.in_blue = 8'($urandom);
    q.operation = OP_SAMPLE;
    q.sample_row = sr;
    q.sample_col = sc;
    push(q);
  endtask

  // Idle, wait for drain, then set size and mode and fill the in-use window.
  task automatic set_image(int h, int w, logic mode, bit extremes);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= REG_HEIGHT; cfg_wdata <= h[8:0];
    @(negedge clk);
    cfg_index <= REG_WIDTH; cfg_wdata <= w[8:0];
    @(negedge clk);
    cfg_index <= REG_MODE; cfg_wdata <= {8'h0, mode};
    @(negedge clk);
    cfg_we <= 1'b0;
    img_h = h; img_w = w;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        put_pixel(r, c, extremes ? (((r + c) % 2) ? 24'hffffff : 24'h000000)
                                 : 24'($urandom));
  endtask

  task automatic random_samples(int n);
    for (int i = 0; i < n; i++) begin
      // mostly in range, some saturating beyond the image
      if ($urandom_range(9) < 8)
        take_sample(16'($urandom_range(img_h * 256 - 1)),
                    16'($urandom_range(img_w * 256 - 1)));
      else
        take_sample(16'($urandom), 16'($urandom));
      if ($urandom_range(9) == 0)
        put_pixel($urandom_range(img_h - 1), $urandom_range(img_w - 1), 24'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed: 1x1 image, checkerboard extremes, corners and saturation.
    set_image(1, 1, MODE_CUBIC, 1'b0);
    take_sample(16'h0000, 16'h0000);
    take_sample(16'hffff, 16'hffff);
    set_image(4, 4, MODE_CUBIC, 1'b1);
    take_sample(16'h0180, 16'h0180);
    take_sample(16'h0000, 16'hffff);
    take_sample(16'h0201, 16'h01ff);
    take_sample(16'h0080, 16'h0080);
    set_image(4, 4, MODE_LINEAR, 1'b1);
    take_sample(16'h0180, 16'h0180);
    take_sample(16'hffff, 16'h0000);
    take_sample(16'h00ff, 16'h00ff);
    // Random phases at several sizes.
    set_image(5, 7, MODE_CUBIC, 1'b0);
    random_samples(80);
    set_image(3, 2, MODE_LINEAR, 1'b0);
    random_samples(60);
    // quiet stretch, then backpressure: receiver holds off while samples queue
    idle_on = 1'b0;
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk);
        hold_off = 1'b0;
      end
      random_samples(20);
    join
    idle_on = 1'b1;
    set_image(1, 90, MODE_CUBIC, 1'b0);
    random_samples(40);
    set_image(90, 1, MODE_LINEAR, 1'b0);
    random_samples(40);
    set_image(8, 8, MODE_CUBIC, 1'b0);
    random_samples(60);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0)
      $display("image_cubic_interpolator: match");
    else
      $display("image_cubic_interpolator: mismatch");
    $finish;
  end

  initial begin
    #20ms;
    $display("image_cubic_interpolator: mismatch");
    $finish;
  end
endmodule

/* image_cubic_interpolator.f */
+incdir+rtl
rtl/ici_pkg.sv
rtl/ici_weight.sv
rtl/ici_lane.sv
rtl/image_cubic_interpolator.sv
sim/interp_checker.sv
sim/testbench.sv
